// ===== rtl/prvex_pkg.sv =====
// prvex_pkg: shared constants, opcodes and transfer structs for the executor
`default_nettype none

package prvex_pkg;

  // storage sizes
  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned SEG_WORDS = MEM_WORDS / 2;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned SEG_AW    = $clog2(SEG_WORDS);

  typedef logic [XLEN-1:0]   word_t;
  typedef logic [REG_AW-1:0] reg_idx_t;
  typedef logic [MEM_AW-1:0] mem_addr_t;
  typedef logic [SEG_AW-1:0] seg_idx_t;

  // pre-decoded operation codes
  typedef enum logic [3:0] {
    FN_ADD  = 4'd0,
    FN_SUB  = 4'd1,
    FN_MUL  = 4'd2,
    FN_ADDI = 4'd3,
    FN_MULI = 4'd4,
    FN_JAL  = 4'd5,
    FN_JALR = 4'd6,
    FN_BEQ  = 4'd7,
    FN_BNE  = 4'd8,
    FN_BLT  = 4'd9,
    FN_BGE  = 4'd10,
    FN_J    = 4'd11,
    FN_LW   = 4'd12,
    FN_SW   = 4'd13,
    FN_NOP  = 4'd14
  } func_t;

  // data memory port request
  typedef struct packed {
    logic      en;
    logic      we;
    mem_addr_t addr;
    word_t     wdata;
  } mem_req_t;

  // register file write
  typedef struct packed {
    logic     en;
    reg_idx_t idx;
    word_t    data;
  } rf_wr_t;

  // execute stage result
  typedef struct packed {
    word_t    npc;
    logic     wb_valid;
    reg_idx_t wb_index;
    word_t    wb_value;
    logic     is_load;
    logic     mem_fault;
  } exec_res_t;

  // finished result as presented on the output
  typedef struct packed {
    word_t    next_pc;
    logic     wb_valid;
    reg_idx_t wb_index;
    word_t    wb_value;
    logic     mem_fault;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/prvex_regfile.sv =====
// prvex_regfile: 32-entry register file, two registered reads, one write
`default_nettype none

module prvex_regfile (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  prvex_pkg::reg_idx_t rd_idx_x,
  input  prvex_pkg::reg_idx_t rd_idx_y,
  input  prvex_pkg::rf_wr_t  wr,
  output prvex_pkg::word_t   rd_data_x,
  output prvex_pkg::word_t   rd_data_y
);
  import prvex_pkg::*;

  word_t                regs [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  word_t                q_x;
  word_t                q_y;
  logic                 qv_x;
  logic                 qv_y;

  // per-entry written flags, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.idx] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      regs[wr.idx] <= wr.data;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_x <= regs[rd_idx_x];
      q_y <= regs[rd_idx_y];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv_x <= 1'b0;
      qv_y <= 1'b0;
    end else if (rd_en) begin
      qv_x <= vld[rd_idx_x];
      qv_y <= vld[rd_idx_y];
    end
  end

  assign rd_data_x = qv_x ? q_x : '0;
  assign rd_data_y = qv_y ? q_y : '0;

endmodule

`default_nettype wire

// ===== rtl/prvex_dmem.sv =====
// prvex_dmem: single-port word data memory with clearing sweep after reset
`default_nettype none

module prvex_dmem (
  input  logic                clk,
  input  logic                rst,
  input  prvex_pkg::mem_req_t req,
  output prvex_pkg::word_t    rd_data,
  output logic                clearing
);
  import prvex_pkg::*;

  word_t     ram [MEM_WORDS];
  mem_addr_t clr_addr;

  // clearing sweep, one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == MEM_AW'(MEM_WORDS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + MEM_AW'(1);
    end
  end

  // write port, shared by the sweep and stores
  always_ff @(posedge clk) begin
    if (!rst && clearing) begin
      ram[clr_addr] <= '0;
    end else if (!rst && req.en && req.we) begin
      ram[req.addr] <= req.wdata;
    end
  end

  // registered read, held until the next load
  always_ff @(posedge clk) begin
    if (!clearing && req.en && !req.we) begin
      rd_data <= ram[req.addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prvex_exec.sv =====
// prvex_exec: execute logic for one instruction, next pc, writeback and memory request
`default_nettype none

module prvex_exec (
  input  logic [3:0]           func,
  input  prvex_pkg::word_t     fa,
  input  prvex_pkg::word_t     fb,
  input  prvex_pkg::word_t     fc,
  input  prvex_pkg::word_t     pc,
  input  logic                 core_id,
  input  prvex_pkg::word_t     opx,
  input  prvex_pkg::word_t     opy,
  output prvex_pkg::exec_res_t res,
  output prvex_pkg::mem_req_t  req
);
  import prvex_pkg::*;

  word_t     pc_inc;
  word_t     mul_b;
  word_t     prod;
  word_t     jalr_tgt;
  word_t     addr_sum;
  logic      all_zero;
  logic      neg;
  logic      addr_ok;
  seg_idx_t  seg_idx;
  mem_addr_t mem_addr;
  reg_idx_t  dst;
  logic      wb;
  word_t     val;

  assign all_zero = (fa == '0) && (fb == '0) && (fc == '0);
  assign pc_inc   = pc + XLEN'(1);
  assign jalr_tgt = opx + fc - XLEN'(1);

  // one shared multiplier, low word only
  assign mul_b = (func_t'(func) == FN_MUL) ? opy : fc;
  assign prod  = opx * mul_b;

  // word address, truncated toward zero, checked against the segment
  assign addr_sum = opx + fb;
  assign neg      = addr_sum[XLEN-1];
  assign addr_ok  = neg ? ((&addr_sum[XLEN-1:2]) && (addr_sum[1:0] != 2'b00))
                        : (addr_sum[XLEN-1:2] < (XLEN-2)'(SEG_WORDS));
  assign seg_idx  = neg ? '0 : addr_sum[SEG_AW+1:2];
  assign mem_addr = MEM_AW'(seg_idx) + (core_id ? MEM_AW'(SEG_WORDS) : '0);
  assign dst      = fa[REG_AW-1:0];

  // opcode decode
  always_comb begin
    res.npc       = pc_inc;
    res.is_load   = 1'b0;
    res.mem_fault = 1'b0;
    req.en        = 1'b0;
    req.we        = 1'b0;
    req.addr      = mem_addr;
    req.wdata     = opy;
    wb            = 1'b0;
    val           = '0;
    if (!all_zero) begin
      unique case (func_t'(func))
        FN_ADD:  begin wb = 1'b1; val = opx + opy; end
        FN_SUB:  begin wb = 1'b1; val = opx - opy; end
        FN_MUL:  begin wb = 1'b1; val = prod; end
        FN_ADDI: begin wb = 1'b1; val = opx + fc; end
        FN_MULI: begin wb = 1'b1; val = prod; end
        FN_JAL: begin
          wb      = 1'b1;
          val     = pc_inc;
          res.npc = fb;
        end
        FN_JALR: begin
          wb      = 1'b1;
          val     = pc_inc;
          res.npc = jalr_tgt;
        end
        FN_BEQ: if (opx == opy) res.npc = fc;
        FN_BNE: if (opx != opy) res.npc = fc;
        FN_BLT: if ($signed(opx) < $signed(opy)) res.npc = fc;
        FN_BGE: if ($signed(opx) >= $signed(opy)) res.npc = fc;
        FN_J:   res.npc = fa;
        FN_LW: begin
          if (addr_ok) begin
            wb          = 1'b1;
            res.is_load = 1'b1;
            req.en      = 1'b1;
          end else begin
            res.mem_fault = 1'b1;
          end
        end
        FN_SW: begin
          if (addr_ok) begin
            req.en = 1'b1;
            req.we = 1'b1;
          end else begin
            res.mem_fault = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // register zero is never written
    if (dst == '0) begin
      wb          = 1'b0;
      res.is_load = 1'b0;
    end
    res.wb_valid = wb;
    res.wb_index = wb ? dst : '0;
    res.wb_value = wb ? val : '0;
  end

endmodule

`default_nettype wire

// ===== rtl/predecoded_rv_core_executor_core.sv =====
// predecoded_rv_core_executor_core: pipelined executor for pre-decoded instructions
//
// Input channel (in_valid/in_stall) carries one instruction per transfer: func and
// three operand fields. Output channel (out_valid/out_stall) carries one result
// per instruction: next_pc, the register writeback and the memory fault flag.
// The configuration channel (cfg_valid/cfg_ready, always ready) writes core_id,
// which picks the half of the data memory this core uses; write it while idle.
// Pipeline: operand read, execute/memory access, output register. One instruction
// per cycle is sustained while the skid register is empty; the single data memory
// port is used at most once per instruction.
// Register and load results are forwarded, so dependent instructions do not wait.
// Reset is synchronous: pc, registers and core_id go to zero, then all MEM_WORDS
// words of the data memory are swept to zero at one word per cycle with in_stall
// high. When the receiver stalls, one result is parked in a skid register and the
// pipeline keeps taking input until that skid is full; then in_stall rises.
`default_nettype none

module predecoded_rv_core_executor_core (
  input  logic               clk,
  input  logic               rst,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  // instruction input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         func,
  input  logic signed [31:0] field_a,
  input  logic signed [31:0] field_b,
  input  logic signed [31:0] field_c,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] next_pc,
  output logic               wb_valid,
  output logic [4:0]         wb_index,
  output logic signed [31:0] wb_value,
  output logic               mem_fault
);
  import prvex_pkg::*;

  logic      core_id;
  word_t     pc;
  logic      clearing;
  logic      adv;
  logic      in_acc;
  reg_idx_t  in_ix;
  reg_idx_t  in_iy;

  // operand read stage
  logic      s1_valid;
  logic [3:0] s1_func;
  word_t     s1_a;
  word_t     s1_b;
  word_t     s1_c;
  reg_idx_t  s1_ix;
  reg_idx_t  s1_iy;
  word_t     rf_x;
  word_t     rf_y;
  word_t     opx;
  word_t     opy;
  exec_res_t ex_res;
  mem_req_t  ex_req;
  mem_req_t  dm_req;
  word_t     dm_rdata;

  // execute stage and last write
  logic      s2_valid;
  exec_res_t s2;
  word_t     s2_val;
  rf_wr_t    rf_wr;
  rf_wr_t    wl;
  result_t   s2_res;

  // output register and skid
  logic      out_take;
  result_t   out_q;
  logic      skid_valid;
  result_t   skid_q;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      core_id <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      core_id <= cfg_data;
    end
  end

  // input transfer and pipeline advance
  assign adv      = !skid_valid;
  assign in_stall = clearing || skid_valid;
  assign in_acc   = in_valid && !in_stall;

  // source register selection per opcode
  always_comb begin
    unique case (func_t'(func)) inside
      FN_BEQ, FN_BNE, FN_BLT, FN_BGE: begin
        in_ix = field_a[REG_AW-1:0];
        in_iy = field_b[REG_AW-1:0];
      end
      FN_LW, FN_SW: begin
        in_ix = field_c[REG_AW-1:0];
        in_iy = field_a[REG_AW-1:0];
      end
      default: begin
        in_ix = field_b[REG_AW-1:0];
        in_iy = field_c[REG_AW-1:0];
      end
    endcase
  end

  prvex_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_acc),
    .rd_idx_x  (in_ix),
    .rd_idx_y  (in_iy),
    .wr        (rf_wr),
    .rd_data_x (rf_x),
    .rd_data_y (rf_y)
  );

  // operand stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func <= func;
      s1_a    <= field_a;
      s1_b    <= field_b;
      s1_c    <= field_c;
      s1_ix   <= in_ix;
      s1_iy   <= in_iy;
    end
  end

  // forwarding: instruction ahead first, then the write made at the read
  assign s2_val = s2.is_load ? dm_rdata : s2.wb_value;

  always_comb begin
    if (s2_valid && s2.wb_valid && (s2.wb_index == s1_ix)) begin
      opx = s2_val;
    end else if (wl.en && (wl.idx == s1_ix)) begin
      opx = wl.data;
    end else begin
      opx = rf_x;
    end
    if (s2_valid && s2.wb_valid && (s2.wb_index == s1_iy)) begin
      opy = s2_val;
    end else if (wl.en && (wl.idx == s1_iy)) begin
      opy = wl.data;
    end else begin
      opy = rf_y;
    end
  end

  prvex_exec u_exec (
    .func    (s1_func),
    .fa      (s1_a),
    .fb      (s1_b),
    .fc      (s1_c),
    .pc      (pc),
    .core_id (core_id),
    .opx     (opx),
    .opy     (opy),
    .res     (ex_res),
    .req     (ex_req)
  );

  // memory access goes with the stage transfer
  always_comb begin
    dm_req    = ex_req;
    dm_req.en = ex_req.en && s1_valid && adv;
  end

  prvex_dmem u_dmem (
    .clk      (clk),
    .rst      (rst),
    .req      (dm_req),
    .rd_data  (dm_rdata),
    .clearing (clearing)
  );

  // program counter, execute stage valid and last write
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      s2_valid <= 1'b0;
      wl.en    <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      wl.en    <= rf_wr.en;
      wl.idx   <= rf_wr.idx;
      wl.data  <= rf_wr.data;
      if (s1_valid) begin
        pc <= ex_res.npc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= ex_res;
    end
  end

  // register writeback at the stage transfer
  assign rf_wr.en   = adv && s2_valid && s2.wb_valid;
  assign rf_wr.idx  = s2.wb_index;
  assign rf_wr.data = s2_val;

  assign s2_res.next_pc   = s2.npc;
  assign s2_res.wb_valid  = s2.wb_valid;
  assign s2_res.wb_index  = s2.wb_index;
  assign s2_res.wb_value  = s2_val;
  assign s2_res.mem_fault = s2.mem_fault;

  // output register with one-entry skid
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= adv && s2_valid;
        end
      end else if (adv && s2_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_q <= skid_valid ? skid_q : s2_res;
    end else if (adv && s2_valid) begin
      skid_q <= s2_res;
    end
  end

  assign next_pc   = out_q.next_pc;
  assign wb_valid  = out_q.wb_valid;
  assign wb_index  = out_q.wb_index;
  assign wb_value  = out_q.wb_value;
  assign mem_fault = out_q.mem_fault;

`ifndef SYNTH
  // a parked result always sits behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  // the skid only fills when the receiver stalled a waiting result
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

  // no instruction enters while the memory is being cleared
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !s1_valid)
    else $error("instruction in flight during memory clearing");

  // a faulting access never reaches the memory
  a_fault_no_access: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && ex_res.mem_fault) |-> !ex_req.en)
    else $error("memory request issued for a faulting address");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_predecoded_rv_core_executor_core.sv =====
// testbench for the pre-decoded instruction executor: directed and random programs checked in order
`default_nettype none

module tb_predecoded_rv_core_executor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import prvex_pkg::*;

  // opcode outside the enum, only advances the pc
  localparam logic [3:0] FN_UNUSED = 4'd15;
  localparam int unsigned SEG_BYTES = SEG_WORDS * 4;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         func = 4'd0;
  logic signed [31:0] field_a = '0;
  logic signed [31:0] field_b = '0;
  logic signed [31:0] field_c = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] next_pc;
  logic               wb_valid;
  logic [4:0]         wb_index;
  logic signed [31:0] wb_value;
  logic               mem_fault;

  predecoded_rv_core_executor_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .field_a   (field_a),
    .field_b   (field_b),
    .field_c   (field_c),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .next_pc   (next_pc),
    .wb_valid  (wb_valid),
    .wb_index  (wb_index),
    .wb_value  (wb_value),
    .mem_fault (mem_fault)
  );

  // architectural state mirrored by the testbench
  word_t    arch_regs [REG_COUNT];
  word_t    arch_mem  [MEM_WORDS];
  word_t    arch_pc;
  logic     arch_core_id;
  result_t  pending_results [$];
  result_t  want;

  int unsigned error_count   = 0;
  int unsigned instr_count   = 0;
  int unsigned result_count  = 0;
  int unsigned write_count   = 0;
  int unsigned fault_count   = 0;
  int unsigned stalled_count = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_request  = 0;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // safety net against a hung handshake
  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("predecoded_rv_core_executor_core: mismatch");
    $finish;
  end

  // register read with register zero hard-wired
  function automatic word_t arch_read(input word_t field);
    return (field[4:0] == 5'd0) ? word_t'(0) : arch_regs[field[4:0]];
  endfunction

  // executes one instruction on the mirrored state
  task automatic arch_execute(input logic [3:0] f, input word_t a, b, c, output result_t r);
    word_t    pc_next;
    word_t    val;
    word_t    sum;
    word_t    mag;
    logic     wr;
    logic     flt;
    logic     in_seg;
    reg_idx_t rd;
    int unsigned word_idx;
    mem_addr_t   mem_idx;
    begin
      pc_next = arch_pc + 1;
      wr = 1'b0;
      flt = 1'b0;
      val = '0;
      rd = a[4:0];
      // word address, truncating toward zero
      sum = arch_read(c) + b;
      if (sum[31]) begin
        mag = ~sum + 1;
        in_seg = (mag[31:2] == 0);
        word_idx = 0;
      end else begin
        in_seg = (sum[31:2] < SEG_WORDS);
        word_idx = sum[31:2];
      end
      mem_idx = mem_addr_t'(arch_core_id * SEG_WORDS + word_idx);
      if (!(a == 0 && b == 0 && c == 0)) begin
        case (f)
          FN_ADD: begin
            wr = 1'b1;
            val = arch_read(b) + arch_read(c);
          end
          FN_SUB: begin
            wr = 1'b1;
            val = arch_read(b) - arch_read(c);
          end
          FN_MUL: begin
            wr = 1'b1;
            val = arch_read(b) * arch_read(c);
          end
          FN_ADDI: begin
            wr = 1'b1;
            val = arch_read(b) + c;
          end
          FN_MULI: begin
            wr = 1'b1;
            val = arch_read(b) * c;
          end
          FN_JAL: begin
            wr = 1'b1;
            val = arch_pc + 1;
            pc_next = b;
          end
          FN_JALR: begin
            wr = 1'b1;
            val = arch_pc + 1;
            pc_next = arch_read(b) + c - 1;
          end
          FN_BEQ: if (arch_read(a) == arch_read(b)) pc_next = c;
          FN_BNE: if (arch_read(a) != arch_read(b)) pc_next = c;
          FN_BLT: if ($signed(arch_read(a)) < $signed(arch_read(b))) pc_next = c;
          FN_BGE: if ($signed(arch_read(a)) >= $signed(arch_read(b))) pc_next = c;
          FN_J: pc_next = a;
          FN_LW: begin
            if (!in_seg) begin
              flt = 1'b1;
            end else begin
              wr = 1'b1;
              val = arch_mem[mem_idx];
            end
          end
          FN_SW: begin
            if (!in_seg) begin
              flt = 1'b1;
            end else begin
              arch_mem[mem_idx] = arch_read(a);
            end
          end
          default: ;
        endcase
      end
      if (rd == 5'd0) wr = 1'b0;
      if (wr) begin
        arch_regs[rd] = val;
      end else begin
        rd = '0;
        val = '0;
      end
      arch_pc = pc_next;
      r.next_pc   = pc_next;
      r.wb_valid  = wr;
      r.wb_index  = rd;
      r.wb_value  = val;
      r.mem_fault = flt;
    end
  endtask

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (!rst && in_valid === 1'b1 && in_stall === 1'b1) stalled_count++;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: next_pc %h", next_pc);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (wb_valid === 1'b1) write_count++;
        if (mem_fault === 1'b1) fault_count++;
        if (next_pc !== want.next_pc) begin
          $error("next_pc expected %h got %h", want.next_pc, next_pc);
          error_count++;
        end
        if (wb_valid !== want.wb_valid) begin
          $error("wb_valid expected %b got %b", want.wb_valid, wb_valid);
          error_count++;
        end
        if (wb_index !== want.wb_index) begin
          $error("wb_index expected %0d got %0d", want.wb_index, wb_index);
          error_count++;
        end
        if (wb_value !== want.wb_value) begin
          $error("wb_value expected %h got %h", want.wb_value, wb_value);
          error_count++;
        end
        if (mem_fault !== want.mem_fault) begin
          $error("mem_fault expected %b got %b", want.mem_fault, mem_fault);
          error_count++;
        end
      end
    end
  end

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned stall_mode;
    hold_left = 0;
    mode_left = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ((mode_left % 4) == 0);
        endcase
      end
    end
  end

  // sender side idles for one cycle, payload turns to noise
  task automatic sender_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    func     <= 4'($urandom);
    field_a  <= $urandom;
    field_b  <= $urandom;
    field_c  <= $urandom;
  endtask

  // one instruction transfer; the expectation is formed on acceptance
  task automatic send_instr(input logic [3:0] f, input word_t a, b, c);
    result_t r;
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= f;
    field_a  <= a;
    field_b  <= b;
    field_c  <= c;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    arch_execute(f, a, b, c, r);
    pending_results.push_back(r);
    instr_count++;
  endtask

  // holds the sender until every expected result is back
  task automatic wait_drained();
    sender_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_core_id(input logic v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    arch_core_id = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // bursts of random length with random gaps between
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 4))
        0: gap = 0;
        1: gap = $urandom_range(8, 30);
        default: gap = $urandom_range(1, 5);
      endcase
      repeat (gap) sender_idle();
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // register choice biased to a few registers so results feed each other
  function automatic reg_idx_t pick_reg();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return reg_idx_t'($urandom_range(0, 31));
      default: return reg_idx_t'($urandom_range(1, 6));
    endcase
  endfunction

  // register field, upper bits sometimes set
  function automatic word_t reg_field(input reg_idx_t idx);
    word_t v;
    v = $urandom;
    if ($urandom_range(0, 3) != 0) v[31:5] = '0;
    v[4:0] = idx;
    return v;
  endfunction

  function automatic word_t rand_imm();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return word_t'($urandom_range(0, 64)) - 32;
      4: return 32'h7fff_ffff;
      5: return 32'h8000_0000;
      6: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // byte address: mostly a small window, some edges and some outside the segment
  function automatic word_t rand_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return word_t'($urandom_range(0, 63));
    if (r < 70) return word_t'($urandom_range(0, SEG_BYTES - 1));
    if (r < 75) return word_t'(0) - $urandom_range(1, 3);
    if (r < 80) return word_t'(SEG_BYTES + $urandom_range(0, 7));
    if (r < 85) return word_t'(0) - $urandom_range(4, 12);
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_func();
    case ($urandom_range(0, 19))
      0: return FN_ADD;
      1: return FN_SUB;
      2: return FN_MUL;
      3, 4: return FN_ADDI;
      5: return FN_MULI;
      6: return FN_JAL;
      7: return FN_JALR;
      8: return FN_BEQ;
      9: return FN_BNE;
      10: return FN_BLT;
      11: return FN_BGE;
      12: return FN_J;
      13, 14, 15: return FN_LW;
      16, 17, 18: return FN_SW;
      default: return FN_NOP;
    endcase
  endfunction

  // well-formed instruction with random content, sometimes noise
  task automatic gen_instr(output logic [3:0] f, output word_t a, b, c);
    if ($urandom_range(0, 99) < 8) f = 4'($urandom_range(0, 15));
    else f = pick_func();
    a = reg_field(pick_reg());
    b = reg_field(pick_reg());
    c = reg_field(pick_reg());
    case (f)
      FN_ADDI, FN_MULI, FN_JALR, FN_BEQ, FN_BNE, FN_BLT, FN_BGE: c = rand_imm();
      FN_JAL: b = rand_imm();
      FN_J: a = rand_imm();
      FN_LW, FN_SW: b = rand_addr() - arch_read(c);
      FN_NOP, FN_UNUSED: begin
        a = $urandom;
        b = $urandom;
        c = $urandom;
      end
      default: ;
    endcase
    if ($urandom_range(0, 49) == 0) begin
      a = '0;
      b = '0;
      c = '0;
    end
  endtask

  // reset, memory sweep, first core_id write
  task automatic test_reset_sweep();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    write_core_id(1'b0);
  endtask

  // every operation and the corner cases, back to back
  task automatic test_directed_ops();
    send_instr(FN_ADDI, 1, 0, 32'h7fff_ffff);
    send_instr(FN_ADDI, 2, 0, 32'h8000_0000);
    send_instr(FN_ADD, 3, 1, 1);
    send_instr(FN_SUB, 4, 2, 1);
    send_instr(FN_MUL, 5, 1, 2);
    send_instr(FN_MULI, 6, 1, 32'hffff_ffff);
    // write to register zero is dropped
    send_instr(FN_ADD, 0, 1, 1);
    // all-zero operands only advance the pc
    send_instr(FN_ADD, 0, 0, 0);
    send_instr(FN_UNUSED, $urandom, $urandom, $urandom);
    send_instr(FN_NOP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_instr(FN_SW, 1, 0, 0);
    send_instr(FN_LW, 7, 0, 0);
    // small negative sums land on word zero
    send_instr(FN_SW, 2, 32'hffff_fffd, 0);
    send_instr(FN_LW, 8, 32'hffff_ffff, 0);
    // outside the segment on both sides, then the last word inside it
    send_instr(FN_LW, 9, 32'hffff_fffc, 0);
    send_instr(FN_SW, 1, SEG_BYTES, 0);
    send_instr(FN_SW, 6, SEG_BYTES - 1, 0);
    send_instr(FN_LW, 32'hffff_ffea, SEG_BYTES - 4, 0);
    // branches taken and not taken
    send_instr(FN_BEQ, 1, 1, 100);
    send_instr(FN_BNE, 1, 1, 200);
    send_instr(FN_BLT, 2, 1, 32'hffff_fffe);
    send_instr(FN_BGE, 2, 1, 300);
    send_instr(FN_BGE, 1, 1, 7);
    // pc wrap through jal, jalr and j
    send_instr(FN_JAL, 11, 32'h7fff_ffff, 0);
    send_instr(FN_JALR, 12, 0, 32'h8000_0000);
    send_instr(FN_J, 32'hffff_ffff, 0, 0);
    send_instr(FN_ADDI, 13, 12, 1);
  endtask

  // random program on one segment, with a full pause half way
  task automatic test_random_core(input logic core, input int unsigned count);
    logic [3:0] f;
    word_t a, b, c;
    write_core_id(core);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      pace_sender();
      gen_instr(f, a, b, c);
      send_instr(f, a, b, c);
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_output_hold();
    logic [3:0] f;
    word_t a, b, c;
    wait_drained();
    @(posedge clk);
    hold_request = 400;
    for (int unsigned i = 0; i < 48; i++) begin
      gen_instr(f, a, b, c);
      send_instr(f, a, b, c);
    end
  endtask

  initial begin
    for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) arch_mem[i] = '0;
    arch_pc = '0;
    arch_core_id = 1'b0;

    test_reset_sweep();
    test_directed_ops();
    test_random_core(1'b0, 225);
    test_random_core(1'b1, 225);
    test_output_hold();
    test_random_core(1'b0, 225);
    test_random_core(1'b1, 225);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("ran %0d instructions on both core segments, %0d results checked",
             instr_count, result_count);
    $display("%0d register writes, %0d memory faults, %0d cycles with input held back",
             write_count, fault_count, stalled_count);
    if (error_count == 0) begin
      $display("predecoded_rv_core_executor_core: match");
    end else begin
      $display("predecoded_rv_core_executor_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
